@@ src/bia_pkg.sv @@
// ----------------------------------------------------------------------------
// bia_pkg
// shared types and constants of the bitmap id allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bia_pkg;

  localparam int unsigned ID_W      = 12;
  localparam int unsigned LIM_W     = 13;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned BIT_W     = 6;
  localparam int unsigned MAX_IDS_DEF = 4096;
  localparam int unsigned ID_SPAN   = 4096;

  localparam logic [LIM_W-1:0] LIMIT_RST = 13'd4096;

  // op codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // register map
  localparam int unsigned APB_AW       = 3;
  localparam logic        REG_ID_LIMIT = 1'b0;

  typedef struct packed {
    logic            op;
    logic [ID_W-1:0] release_id;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] granted_id;
    logic            success;
  } out_item_t;

endpackage

`default_nettype wire

@@ src/bitmap_id_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// lowest-free id allocator over a word memory with a full-word summary
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------
//  in_     | input     | in_valid / in_stall  | in_data  (op, release_id)
//  out_    | output    | out_valid / out_stall| out_data (granted_id, success)
//  apb     | input     | psel/penable/pwrite  | paddr, pwdata, prdata
//
//  an item is accepted in the idle state, which picks the word from the full-word
//  summary and reads the bitmap memory; the modify state then finds the first zero,
//  writes the word back and loads the output register
//  the bitmap memory is used as one port: one read and at most one write per item,
//  and a new item is accepted only once the last one leaves the modify state
//  reset is synchronous; memory words carry valid bits, so no clearing pass
//  a stalled output holds the item back in the modify state until taken
`default_nettype none

module bitmap_id_allocator #(
  parameter int unsigned MAX_IDS = bia_pkg::MAX_IDS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // input item channel
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire bia_pkg::in_item_t           in_data,
  // result channel
  output logic                             out_valid,
  input  wire                              out_stall,
  output bia_pkg::out_item_t               out_data,
  // configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [bia_pkg::APB_AW-1:0]        paddr,
  input  wire [31:0]                       pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  // words actually reachable: ids never exceed the 12-bit field
  localparam int unsigned POOL_WORDS = (MAX_IDS + bia_pkg::WORD_W - 1) / bia_pkg::WORD_W;
  localparam int unsigned SPAN_WORDS = bia_pkg::ID_SPAN / bia_pkg::WORD_W;
  localparam int unsigned USE_WORDS  = (POOL_WORDS < SPAN_WORDS) ? POOL_WORDS : SPAN_WORDS;
  localparam int unsigned WA         = (USE_WORDS > 1) ? $clog2(USE_WORDS) : 1;
  localparam int unsigned DEPTH      = 1 << WA;
  localparam int unsigned MAX_EFF    = (MAX_IDS < bia_pkg::ID_SPAN) ? MAX_IDS : bia_pkg::ID_SPAN;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_MOD  = 1'b1;

  localparam int unsigned LIM_W = bia_pkg::LIM_W;
  localparam int unsigned ID_W  = bia_pkg::ID_W;
  localparam int unsigned BIT_W = bia_pkg::BIT_W;
  localparam int unsigned WW    = bia_pkg::WORD_W;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [LIM_W-1:0] id_limit_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == bia_pkg::REG_ID_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_limit_r <= bia_pkg::LIMIT_RST;
    end else if (cfg_wr) begin
      id_limit_r <= pwdata[LIM_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == bia_pkg::REG_ID_LIMIT) begin
      prdata = {{(32-LIM_W){1'b0}}, id_limit_r};
    end
  end

  // effective limit, clamped to the pool and the id field
  logic [LIM_W-1:0] lim;
  logic [LIM_W:0]   lim_words;   // number of words with at least one usable id

  assign lim = (id_limit_r > LIM_W'(MAX_EFF)) ? LIM_W'(MAX_EFF) : id_limit_r;
  assign lim_words = ({1'b0, lim} + (LIM_W+1)'(WW - 1)) >> BIT_W;

  // --------------------------------------------------------------------------
  // control and bitmap state
  // --------------------------------------------------------------------------
  logic              state_r, state_nxt;
  logic              op_r;
  logic [ID_W-1:0]   rid_r;
  logic [WA-1:0]     word_r;
  logic              found_r;
  logic [DEPTH-1:0]  full_r;      // summary: word is all ones
  logic [DEPTH-1:0]  ram_vld_r;   // word written since reset
  logic [WW-1:0]     ram_q_r;
  logic              ram_q_vld_r;
  logic              out_valid_r;
  bia_pkg::out_item_t out_data_r;

  logic [WW-1:0]     bitmap [DEPTH];

  logic              in_acc;
  logic              done;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign done      = (state_r == S_MOD) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // pick the lowest word that is not full and still holds usable ids
  logic          sel_found;
  logic [WA-1:0] sel_word;

  always_comb begin
    sel_found = 1'b0;
    sel_word  = '0;
    for (int i = USE_WORDS - 1; i >= 0; i--) begin
      if (!full_r[i] && ((LIM_W+1)'(i) < lim_words)) begin
        sel_found = 1'b1;
        sel_word  = WA'(i);
      end
    end
  end

  logic [WA-1:0] rd_addr;
  assign rd_addr = (in_data.op == bia_pkg::OP_RELEASE) ? in_data.release_id[BIT_W +: WA]
                                                       : sel_word;

  // --------------------------------------------------------------------------
  // modify stage: find first zero, build write-back word and result
  // --------------------------------------------------------------------------
  logic [WW-1:0]    cur_word;
  logic [BIT_W-1:0] fz_bit;
  logic             fz_found;
  logic [ID_W-1:0]  alloc_id;
  logic             grant;
  logic             rel_ok;
  logic [WW-1:0]    new_word;
  logic             wr_en;

  assign cur_word = ram_q_vld_r ? ram_q_r : '0;

  always_comb begin
    fz_found = 1'b0;
    fz_bit   = '0;
    for (int b = WW - 1; b >= 0; b--) begin
      if (!cur_word[b]) begin
        fz_found = 1'b1;
        fz_bit   = BIT_W'(b);
      end
    end
  end

  assign alloc_id = ID_W'({word_r, fz_bit});
  assign grant    = (op_r == bia_pkg::OP_ALLOC) && found_r && fz_found
                    && ({1'b0, alloc_id} < lim);
  assign rel_ok   = (op_r == bia_pkg::OP_RELEASE) && ({1'b0, rid_r} < lim);
  assign new_word = (op_r == bia_pkg::OP_RELEASE)
                    ? (cur_word & ~(WW'(1) << rid_r[BIT_W-1:0]))
                    : (cur_word | (WW'(1) << fz_bit));
  assign wr_en    = done && (grant || rel_ok);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_MOD;
      S_MOD:   if (done)   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      full_r      <= '0;
      ram_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        full_r[word_r]    <= (op_r == bia_pkg::OP_ALLOC) && (&new_word);
        ram_vld_r[word_r] <= 1'b1;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r        <= in_data.op;
      rid_r       <= in_data.release_id;
      word_r      <= rd_addr;
      found_r     <= sel_found;
      ram_q_vld_r <= ram_vld_r[rd_addr];
    end
    if (done) begin
      out_data_r.granted_id <= grant ? alloc_id : '0;
      out_data_r.success    <= grant || rel_ok;
    end
  end

  // bitmap memory, one read at accept, at most one write at the end of the modify step
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ram_q_r <= bitmap[rd_addr];
    end
    if (wr_en) begin
      bitmap[word_r] <= new_word;
    end
  end

endmodule

`default_nettype wire
